// File: design/assert_macros.svh
// assertion macros for the checker file of the heap sort engine
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define HSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define HSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/hse_pkg.sv
// shared types and constants of the heap sort engine
// no dependencies
`default_nettype none

package hse_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflowed;
  } out_beat_t;

  typedef struct packed {
    logic take_right;
    logic stop;
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_RD,
    ST_BLD_GET,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_RD,
    ST_EXT_SWP,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_t;

endpackage

`default_nettype wire

// File: design/heap_sort_engine_unit.sv
// heap sort engine top level: load sequencer, heap sequencer and output register
// depends on hse_pkg, hse_store, hse_cmp
//
// input beats (value, last) are taken one per cycle while in_ready is high and
// written into the element store. beats beyond CAPACITY are dropped and flag
// overflowed on every result of that run. a beat with last set closes the run:
// in_ready drops and the block heap-sorts what it holds with one shared
// compare unit, then streams the values out in ascending order, final_res set
// on the last one. in_ready returns once the final result is in the output
// register, so the next run loads while that result waits.
// sorting n held values runs floor(n/2)+1 build sifts and n-1 extractions. each
// sift fetches its start value, then per level reads both children from the
// store and compares them in the single compare unit, and writes the value
// back where it stops. each result is read from the store and then loaded into
// the output register. a stalled receiver holds the output register and the
// sequencer waits.
// reset (synchronous, rst_n low) zeroes the element count, which empties the store, and clears out_valid.
`default_nettype none

module heap_sort_engine_unit #(
  parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hse_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hse_pkg::out_beat_t     out_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = ADDR_W + 2;

  hse_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0] node_r, node_nxt;
  logic [ADDR_W-1:0] lc_r, lc_nxt;
  logic              hasr_r, hasr_nxt;
  logic              ext_r, ext_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic signed [hse_pkg::DATA_W-1:0] v_r, v_nxt;
  logic              out_valid_r, out_valid_nxt;
  hse_pkg::out_beat_t out_data_r, out_data_nxt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic signed [hse_pkg::DATA_W-1:0] mem_wdata, rd_a, rd_b, child_val;
  hse_pkg::cmp_res_t cmp_res;

  logic [IDX_W-1:0]  lc_idx, rc_idx;
  logic              sift_done;

  hse_store #(.DEPTH(CAPACITY), .ADDR_W(ADDR_W)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  hse_cmp u_cmp (
    .hole_val  (v_r),
    .left_val  (rd_a),
    .right_val (rd_b),
    .has_right (hasr_r),
    .child_val (child_val),
    .res       (cmp_res)
  );

  assign lc_idx = {1'b0, node_r, 1'b1};
  assign rc_idx = lc_idx + IDX_W'(1);

  assign in_ready  = (state_r == hse_pkg::ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hse_pkg::ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    size_r     <= size_nxt;
    node_r     <= node_nxt;
    lc_r       <= lc_nxt;
    hasr_r     <= hasr_nxt;
    ext_r      <= ext_nxt;
    j_r        <= j_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    size_nxt      = size_r;
    node_nxt      = node_r;
    lc_nxt        = lc_r;
    hasr_nxt      = hasr_r;
    ext_nxt       = ext_r;
    j_nxt         = j_r;
    v_nxt         = v_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = v_r;
    mem_re        = 1'b0;
    mem_raddr_a   = node_r;
    mem_raddr_b   = node_r;
    sift_done     = 1'b0;

    unique case (state_r)
      hse_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(CAPACITY)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[ADDR_W-1:0];
            mem_wdata = in_data.value;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            k_nxt     = count_nxt >> 1;
            ext_nxt   = 1'b0;
            state_nxt = hse_pkg::ST_BLD_RD;
          end
        end
      end
      hse_pkg::ST_BLD_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = k_r[ADDR_W-1:0];
        state_nxt   = hse_pkg::ST_BLD_GET;
      end
      hse_pkg::ST_BLD_GET: begin
        v_nxt     = rd_a;
        node_nxt  = k_r[ADDR_W-1:0];
        size_nxt  = count_r;
        state_nxt = hse_pkg::ST_SIFT_RD;
      end
      hse_pkg::ST_SIFT_RD: begin
        if (lc_idx < IDX_W'(size_r)) begin
          mem_re      = 1'b1;
          mem_raddr_a = lc_idx[ADDR_W-1:0];
          mem_raddr_b = rc_idx[ADDR_W-1:0];
          lc_nxt      = lc_idx[ADDR_W-1:0];
          hasr_nxt    = (rc_idx < IDX_W'(size_r));
          state_nxt   = hse_pkg::ST_SIFT_CMP;
        end else begin
          mem_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      hse_pkg::ST_SIFT_CMP: begin
        mem_we = 1'b1;
        if (cmp_res.stop) begin
          sift_done = 1'b1;
        end else begin
          mem_wdata = child_val;
          node_nxt  = cmp_res.take_right ? lc_r + ADDR_W'(1) : lc_r;
          state_nxt = hse_pkg::ST_SIFT_RD;
        end
      end
      hse_pkg::ST_EXT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = '0;
        mem_raddr_b = ADDR_W'(k_r - CNT_W'(1));
        state_nxt   = hse_pkg::ST_EXT_SWP;
      end
      hse_pkg::ST_EXT_SWP: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(k_r - CNT_W'(1));
        mem_wdata = rd_a;
        v_nxt     = rd_b;
        node_nxt  = '0;
        size_nxt  = k_r - CNT_W'(1);
        state_nxt = hse_pkg::ST_SIFT_RD;
      end
      hse_pkg::ST_OUT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = j_r[ADDR_W-1:0];
        state_nxt   = hse_pkg::ST_OUT_LOAD;
      end
      hse_pkg::ST_OUT_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.sorted_value = rd_a;
          out_data_nxt.final_res    = (j_r + CNT_W'(1) == count_r);
          out_data_nxt.overflowed   = ovf_r;
          j_nxt = j_r + CNT_W'(1);
          if (j_r + CNT_W'(1) == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = hse_pkg::ST_LOAD;
          end else begin
            state_nxt = hse_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = hse_pkg::ST_LOAD;
      end
    endcase

    // return from a finished sift
    if (sift_done) begin
      j_nxt = '0;
      if (ext_r) begin
        k_nxt = k_r - CNT_W'(1);
        state_nxt = (k_r - CNT_W'(1) > CNT_W'(1)) ? hse_pkg::ST_EXT_RD : hse_pkg::ST_OUT_RD;
      end else if (k_r == '0) begin
        k_nxt     = count_r;
        ext_nxt   = 1'b1;
        state_nxt = (count_r > CNT_W'(1)) ? hse_pkg::ST_EXT_RD : hse_pkg::ST_OUT_RD;
      end else begin
        k_nxt     = k_r - CNT_W'(1);
        state_nxt = hse_pkg::ST_BLD_RD;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/hse_store.sv
// element store: one write port, two read ports with registered read data
// depends on hse_pkg
`default_nettype none

module hse_store #(
  parameter int DEPTH  = hse_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [ADDR_W-1:0]                waddr,
  input  wire logic signed [hse_pkg::DATA_W-1:0] wdata,
  input  wire logic                             re,
  input  wire logic [ADDR_W-1:0]                raddr_a,
  input  wire logic [ADDR_W-1:0]                raddr_b,
  output logic signed [hse_pkg::DATA_W-1:0]      rdata_a,
  output logic signed [hse_pkg::DATA_W-1:0]      rdata_b
);

  logic signed [hse_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: design/hse_cmp.sv
// shared compare unit of one sift step: picks the larger child, decides stop
// depends on hse_pkg
`default_nettype none

module hse_cmp (
  input  wire logic signed [hse_pkg::DATA_W-1:0] hole_val,
  input  wire logic signed [hse_pkg::DATA_W-1:0] left_val,
  input  wire logic signed [hse_pkg::DATA_W-1:0] right_val,
  input  wire logic                             has_right,
  output logic signed [hse_pkg::DATA_W-1:0]      child_val,
  output hse_pkg::cmp_res_t                     res
);

  always_comb begin
    res.take_right = has_right && (left_val < right_val);
    child_val      = res.take_right ? right_val : left_val;
    res.stop       = (hole_val >= child_val);
  end

endmodule

`default_nettype wire

// File: design/hse_checker.sv
// port-level checker for heap_sort_engine_unit, attached by bind
// depends on hse_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module hse_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire hse_pkg::in_beat_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hse_pkg::out_beat_t out_data
);

  // stalled result beat holds
  `HSE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // a closing beat makes the block busy
  `HSE_ASSERT(a_busy_after_last, in_valid && in_ready && in_data.last |=> !in_ready, "ready after last beat")

  // no loading while a run is still being emitted
  `HSE_ASSERT(a_no_load_mid_run, out_valid && !out_data.final_res |-> !in_ready, "ready mid run")

  // reset empties the output register
  `HSE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (.*);

`default_nettype wire

// File: dv/heap_sort_checker.sv
// checker for the heap sort engine: watches the input and result channels,
// predicts the sorted output of each run and compares it beat by beat
// depends on hse_pkg
`timescale 1ns / 100ps

module heap_sort_checker #(
  parameter int CAPACITY = hse_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  hse_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  hse_pkg::out_beat_t out_data,
  output int                 mismatch_count,
  output int                 results_due
);

  logic signed [hse_pkg::DATA_W-1:0] held_values [CAPACITY];
  int                                held_count;
  logic                              overflow_seen;
  hse_pkg::out_beat_t                sorted_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // ascending order of the held values, then one expected beat per value
  task automatic close_run();
    logic signed [hse_pkg::DATA_W-1:0] key;
    int                                i;
    int                                j;
    hse_pkg::out_beat_t                beat;
    for (i = 1; i < held_count; i++) begin
      key = held_values[i];
      j = i - 1;
      while (j >= 0 && held_values[j] > key) begin
        held_values[j + 1] = held_values[j];
        j--;
      end
      held_values[j + 1] = key;
    end
    for (i = 0; i < held_count; i++) begin
      beat.sorted_value = held_values[i];
      beat.final_res    = (i == held_count - 1);
      beat.overflowed   = overflow_seen;
      sorted_due.push_back(beat);
    end
    held_count    = 0;
    overflow_seen = 1'b0;
  endtask

  task automatic take_element(input hse_pkg::in_beat_t beat);
    if (held_count < CAPACITY) begin
      held_values[held_count] = beat.value;
      held_count++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (beat.last) close_run();
  endtask

  task automatic check_result(input hse_pkg::out_beat_t got);
    hse_pkg::out_beat_t want;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with none expected", got.sorted_value));
    end else begin
      want = sorted_due.pop_front();
      if (got.sorted_value !== want.sorted_value)
        report_mismatch($sformatf("sorted_value got %0d expected %0d",
                                  got.sorted_value, want.sorted_value));
      if (got.final_res !== want.final_res)
        report_mismatch($sformatf("final_res got %b expected %b",
                                  got.final_res, want.final_res));
      if (got.overflowed !== want.overflowed)
        report_mismatch($sformatf("overflowed got %b expected %b",
                                  got.overflowed, want.overflowed));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatch_count = 0;
      held_count     = 0;
      overflow_seen  = 1'b0;
      sorted_due.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) take_element(in_data);
    end
    results_due = sorted_due.size();
  end

endmodule

// File: dv/tb_heap_sort_engine_unit.sv
// testbench top for the heap sort engine: clock, reset, input beats and
// result back-pressure; checking is left to heap_sort_checker
// depends on hse_pkg, heap_sort_engine_unit and heap_sort_checker
`timescale 1ns / 100ps

module tb_heap_sort_engine_unit;

  localparam int CAP = hse_pkg::CAPACITY_DEF;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  hse_pkg::in_beat_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hse_pkg::out_beat_t out_data;
  logic               quiet     = 1'b0;
  int                 mismatch_count;
  int                 results_due;
  int                 beats_sent;

  heap_sort_engine_unit #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  heap_sort_checker #(.CAPACITY(CAP)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  task automatic send_element(input logic signed [hse_pkg::DATA_W-1:0] val,
                              input logic is_last);
    hse_pkg::in_beat_t beat;
    beat.value = val;
    beat.last  = is_last;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // hold the input off until every expected beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [hse_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int k = 0; k < size; k++) send_element(pick_value(), k == size - 1);
  endtask

  function automatic int pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 16);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    beats_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element, most negative
    send_element(32'h8000_0000, 1'b1);
    // extremes mixed with zero and unit values
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(0, 1'b0);
    send_element(-1, 1'b0);
    send_element(1, 1'b1);
    // equal values kept apart
    send_element(7, 1'b0);
    send_element(7, 1'b0);
    send_element(-7, 1'b0);
    send_element(7, 1'b1);
    // reverse order
    send_element(3, 1'b0);
    send_element(2, 1'b0);
    send_element(1, 1'b1);
    drain_results();

    beats_sent = 0;
    while (beats_sent < 40) send_set(pick_size());

    // full store, two dropped beats and a dropped last beat, no idling
    quiet <= 1'b1;
    send_set(CAP + 3);
    send_set(pick_size());
    drain_results();
    quiet <= 1'b0;

    while (beats_sent < 160) send_set(pick_size());
    drain_results();
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
